// ===== rtl/bdha_pkg.sv =====
// Shared constants and types for the debounced button with hold actions.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package bdha_pkg;

    localparam int MAX_HOLD_ACTIONS = 4;
    localparam int PACKED_ACTIONS   = 4;
    localparam int LIVE_LIMIT       = (MAX_HOLD_ACTIONS < PACKED_ACTIONS) ?
                                      MAX_HOLD_ACTIONS : PACKED_ACTIONS;

    localparam int HOLD_W   = 24;
    localparam int THR_W    = 16;
    localparam int KIND_W   = 8;
    localparam int CYC_W    = 8;
    localparam int STABLE_W = 9;
    localparam int DEB_W    = 8;
    localparam int CNT_W    = 3;

    localparam int DIV_STEPS = HOLD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam int IN_W  = 8;
    localparam int OUT_W = 56;

    localparam logic [HOLD_W-1:0]   HOLD_MAX   = {HOLD_W{1'b1}};
    localparam logic [STABLE_W-1:0] STABLE_MAX = {STABLE_W{1'b1}};

    // Reset values of the configuration registers.
    localparam logic              RST_ACTIVE_LOW = 1'b1;
    localparam logic [DEB_W-1:0]  RST_DEBOUNCE   = 8'd50;
    localparam logic [THR_W-1:0]  RST_LONG_PRESS = 16'd1000;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_ACTIVE_LOW   = 3'd0,
        REG_DEBOUNCE_MS  = 3'd1,
        REG_LONG_PRESS   = 3'd2,
        REG_ACTION_COUNT = 3'd3,
        REG_THRESHOLDS   = 3'd4,
        REG_ON_RELEASE   = 3'd5,
        REG_KINDS        = 3'd6
    } cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/button_debounce_hold_actions.sv =====
// Debounced push button with long-press detection and hold actions.
// Uses bdha_pkg for widths, register indexes and constants.
// The result word passes the finish state and the output register after an input word is accepted,
// and first runs through the 24-step serial divider when the preview cycle needs it.
// s_tready is high only when idle: it stays low through the divider, the finish step and a full output register.
// Reset (rst_n, asynchronous, active low) restores the register defaults and the
// released, idle state; the output register comes up empty.
`default_nettype none

module button_debounce_hold_actions (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [bdha_pkg::IN_W-1:0]     s_tdata,   // [0] raw_level
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] pressed, [24:1] hold_ms, [25] press_event, [26] long_press_event,
    // [27] short_press_event, [28] action_valid, [36:29] action_kind,
    // [44:37] action_cycle, [45] preview_valid, [53:46] preview_cycle
    output logic [bdha_pkg::OUT_W-1:0]         m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [63:0]                   cfg_data
);

    localparam int HW  = bdha_pkg::HOLD_W;
    localparam int TW  = bdha_pkg::THR_W;
    localparam int NA  = bdha_pkg::MAX_HOLD_ACTIONS;
    localparam int NL  = bdha_pkg::LIVE_LIMIT;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic                            active_low_reg,    active_low_next;
    logic [bdha_pkg::DEB_W-1:0]      debounce_reg,      debounce_next;
    logic [TW-1:0]                   long_press_reg,    long_press_next;
    logic [bdha_pkg::CNT_W-1:0]      action_count_reg,  action_count_next;
    logic [63:0]                     thresholds_reg,    thresholds_next;
    logic [3:0]                      on_release_reg,    on_release_next;
    logic [31:0]                     kinds_reg,         kinds_next;

    // Button state
    logic                            last_raw_reg,      last_raw_next;
    logic                            debounced_reg,     debounced_next;
    logic [bdha_pkg::STABLE_W-1:0]   stable_reg,        stable_next;
    logic [HW-1:0]                   hold_reg,          hold_next;
    logic [HW-1:0]                   dur_reg,           dur_next;
    logic                            released_reg,      released_next;
    logic                            long_fired_reg,    long_fired_next;
    logic [bdha_pkg::CYC_W-1:0]      cycle_reg,         cycle_next;
    logic [NA-1:0]                   fired_reg,         fired_next;
    logic                            div_used_reg,      div_used_next;

    // Serial divider
    logic [HW-1:0]                   div_sh_reg,        div_sh_next;
    logic [TW-1:0]                   div_rem_reg,       div_rem_next;
    logic [bdha_pkg::CYC_W-1:0]      div_q_reg,         div_q_next;
    logic [bdha_pkg::STEP_W-1:0]     div_cnt_reg,       div_cnt_next;

    // Output register
    logic                            m_tvalid_reg,      m_tvalid_next;
    logic [bdha_pkg::OUT_W-1:0]      m_tdata_reg,       m_tdata_next;

    logic [TW-1:0]                   t0;
    logic [bdha_pkg::CNT_W-1:0]      live_n;
    logic [TW:0]                     rem_sh;

    assign t0        = thresholds_reg[TW-1:0];
    assign live_n    = (action_count_reg > bdha_pkg::CNT_W'(NL)) ?
                       bdha_pkg::CNT_W'(NL) : action_count_reg;
    assign rem_sh    = {div_rem_reg, div_sh_reg[HW-1]};
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        logic                          r;
        logic                          adopt;
        logic                          deb_new;
        logic [HW-1:0]                 dur;
        logic                          found;
        logic [bdha_pkg::CYC_W-1:0]    cyc;
        logic                          ev_press;
        logic                          ev_long;
        logic                          ev_short;
        logic                          act_v;
        logic [bdha_pkg::KIND_W-1:0]   act_k;
        logic [bdha_pkg::CYC_W-1:0]    act_c;
        logic                          prev_v;
        logic [bdha_pkg::CYC_W-1:0]    prev_c;
        logic [TW-1:0]                 thr_i;

        state_next        = state_reg;
        active_low_next   = active_low_reg;
        debounce_next     = debounce_reg;
        long_press_next   = long_press_reg;
        action_count_next = action_count_reg;
        thresholds_next   = thresholds_reg;
        on_release_next   = on_release_reg;
        kinds_next        = kinds_reg;
        last_raw_next     = last_raw_reg;
        debounced_next    = debounced_reg;
        stable_next       = stable_reg;
        hold_next         = hold_reg;
        dur_next          = dur_reg;
        released_next     = released_reg;
        long_fired_next   = long_fired_reg;
        cycle_next        = cycle_reg;
        fired_next        = fired_reg;
        div_used_next     = div_used_reg;
        div_sh_next       = div_sh_reg;
        div_rem_next      = div_rem_reg;
        div_q_next        = div_q_reg;
        div_cnt_next      = div_cnt_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;

        r        = s_tdata[0] ^ active_low_reg;
        adopt    = 1'b0;
        deb_new  = debounced_reg;
        dur      = '0;
        found    = 1'b0;
        cyc      = cycle_reg;
        ev_press = 1'b0;
        ev_long  = 1'b0;
        ev_short = 1'b0;
        act_v    = 1'b0;
        act_k    = '0;
        act_c    = '0;
        prev_v   = 1'b0;
        prev_c   = '0;
        thr_i    = '0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    // Debounce: count ticks since the corrected level last changed.
                    if (r != last_raw_reg)
                        stable_next = '0;
                    else if (stable_reg < bdha_pkg::STABLE_MAX)
                        stable_next = stable_reg + 1'b1;
                    last_raw_next = r;

                    if (debounced_reg)
                        dur = (hold_reg < bdha_pkg::HOLD_MAX) ? hold_reg + 1'b1 :
                              bdha_pkg::HOLD_MAX;

                    adopt = (stable_next > {1'b0, debounce_reg}) && (r != debounced_reg);
                    released_next = 1'b0;
                    if (adopt)
                    begin
                        deb_new = r;
                        if (r)
                        begin
                            dur             = '0;
                            long_fired_next = 1'b0;
                            cycle_next      = '0;
                            fired_next      = '0;
                        end
                        else
                        begin
                            released_next = 1'b1;
                        end
                    end
                    debounced_next = deb_new;
                    dur_next       = dur;
                    hold_next      = deb_new ? dur : '0;

                    div_sh_next   = deb_new ? dur : '0;
                    div_rem_next  = '0;
                    div_q_next    = '0;
                    div_cnt_next  = '0;
                    div_used_next = deb_new && (live_n != '0) && (t0 != '0) &&
                                    (dur >= {{(HW-TW){1'b0}}, t0});
                    state_next    = (deb_new && (live_n != '0) && (t0 != '0) &&
                                    (dur >= {{(HW-TW){1'b0}}, t0})) ? ST_DIV : ST_FIN;
                end
            end

            ST_DIV:
            begin
                // One restoring step per cycle; only the low quotient bits are kept.
                if (rem_sh >= {1'b0, t0})
                begin
                    div_rem_next = TW'(rem_sh - {1'b0, t0});
                    div_q_next   = {div_q_reg[bdha_pkg::CYC_W-2:0], 1'b1};
                end
                else
                begin
                    div_rem_next = rem_sh[TW-1:0];
                    div_q_next   = {div_q_reg[bdha_pkg::CYC_W-2:0], 1'b0};
                end
                div_sh_next = {div_sh_reg[HW-2:0], 1'b0};
                if (div_cnt_reg == bdha_pkg::STEP_W'(bdha_pkg::DIV_STEPS - 1))
                    state_next = ST_FIN;
                else
                    div_cnt_next = div_cnt_reg + 1'b1;
            end

            ST_FIN:
            begin
                if (live_n == '0)
                begin
                    ev_press = released_reg && !long_fired_reg;
                    if (debounced_reg && !long_fired_reg &&
                        (hold_reg >= {{(HW-TW){1'b0}}, long_press_reg}))
                    begin
                        long_fired_next = 1'b1;
                        ev_long         = 1'b1;
                    end
                end
                else if (debounced_reg)
                begin
                    if (div_used_reg && (div_q_reg != cycle_reg))
                    begin
                        cycle_next = div_q_reg;
                        cyc        = div_q_reg;
                        prev_v     = 1'b1;
                        prev_c     = div_q_reg;
                    end
                    for (int i = 0; i < NL; i++)
                    begin
                        thr_i = thresholds_reg[i*TW +: TW];
                        if (!found && (bdha_pkg::CNT_W'(i) < live_n) &&
                            (hold_reg >= {{(HW-TW){1'b0}}, thr_i}) &&
                            !on_release_reg[i] && !fired_reg[i])
                        begin
                            found         = 1'b1;
                            fired_next[i] = 1'b1;
                            act_v         = 1'b1;
                            act_k         = kinds_reg[i*bdha_pkg::KIND_W +: bdha_pkg::KIND_W];
                            act_c         = cyc;
                        end
                    end
                end
                else if (released_reg)
                begin
                    // The highest qualifying release action wins.
                    for (int i = NL - 1; i >= 0; i--)
                    begin
                        thr_i = thresholds_reg[i*TW +: TW];
                        if (!found && (bdha_pkg::CNT_W'(i) < live_n) &&
                            (dur_reg >= {{(HW-TW){1'b0}}, thr_i}) &&
                            on_release_reg[i] && !fired_reg[i])
                        begin
                            found = 1'b1;
                            act_v = 1'b1;
                            act_k = kinds_reg[i*bdha_pkg::KIND_W +: bdha_pkg::KIND_W];
                            act_c = cycle_reg;
                        end
                    end
                    if (!found && (dur_reg < {{(HW-TW){1'b0}}, t0}))
                        ev_short = 1'b1;
                end

                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, prev_c, prev_v, act_c, act_k, act_v,
                                     ev_short, ev_long, ev_press, hold_reg, debounced_reg};
                    state_next    = ST_IDLE;
                end
                else
                begin
                    // Hold the state updates until the output word can be written.
                    long_fired_next = long_fired_reg;
                    cycle_next      = cycle_reg;
                    fired_next      = fired_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid)
        begin
            unique case (cfg_index)
                bdha_pkg::REG_ACTIVE_LOW:   active_low_next = cfg_data[0];
                bdha_pkg::REG_DEBOUNCE_MS:  debounce_next   = cfg_data[bdha_pkg::DEB_W-1:0];
                bdha_pkg::REG_LONG_PRESS:   long_press_next = cfg_data[TW-1:0];
                bdha_pkg::REG_ACTION_COUNT:
                begin
                    action_count_next = cfg_data[bdha_pkg::CNT_W-1:0];
                    fired_next        = '0;
                end
                bdha_pkg::REG_THRESHOLDS:   thresholds_next = cfg_data;
                bdha_pkg::REG_ON_RELEASE:   on_release_next = cfg_data[3:0];
                bdha_pkg::REG_KINDS:        kinds_next      = cfg_data[31:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            active_low_reg   <= bdha_pkg::RST_ACTIVE_LOW;
            debounce_reg     <= bdha_pkg::RST_DEBOUNCE;
            long_press_reg   <= bdha_pkg::RST_LONG_PRESS;
            action_count_reg <= '0;
            thresholds_reg   <= '0;
            on_release_reg   <= '0;
            kinds_reg        <= '0;
            last_raw_reg     <= 1'b0;
            debounced_reg    <= 1'b0;
            stable_reg       <= '0;
            hold_reg         <= '0;
            released_reg     <= 1'b0;
            long_fired_reg   <= 1'b0;
            cycle_reg        <= '0;
            fired_reg        <= '0;
            div_used_reg     <= 1'b0;
            div_cnt_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            active_low_reg   <= active_low_next;
            debounce_reg     <= debounce_next;
            long_press_reg   <= long_press_next;
            action_count_reg <= action_count_next;
            thresholds_reg   <= thresholds_next;
            on_release_reg   <= on_release_next;
            kinds_reg        <= kinds_next;
            last_raw_reg     <= last_raw_next;
            debounced_reg    <= debounced_next;
            stable_reg       <= stable_next;
            hold_reg         <= hold_next;
            released_reg     <= released_next;
            long_fired_reg   <= long_fired_next;
            cycle_reg        <= cycle_next;
            fired_reg        <= fired_next;
            div_used_reg     <= div_used_next;
            div_cnt_reg      <= div_cnt_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        dur_reg     <= dur_next;
        div_sh_reg  <= div_sh_next;
        div_rem_reg <= div_rem_next;
        div_q_reg   <= div_q_next;
        m_tdata_reg <= m_tdata_next;
    end

    // An accepted word always leaves the idle state for the divider or the finish step.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> (state_reg == ST_DIV) || (state_reg == ST_FIN))
        else $error("accepted word did not start processing");

    // The divider step counter never runs past the last step.
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_cnt_reg < bdha_pkg::STEP_W'(bdha_pkg::DIV_STEPS)))
        else $error("divider step counter out of range");

    // Simple-mode and action-mode events never appear in the same word.
    a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !((m_tdata[25] || m_tdata[26]) && (m_tdata[27] || m_tdata[28] ||
                       m_tdata[45])))
        else $error("simple and action events mixed");

    // A released button reports zero hold time.
    a_hold_released: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[24:1] == '0))
        else $error("hold time nonzero while released");

    // The state is written once per word: the finish step always leaves a valid word.
    a_fin_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) && (state_next == ST_IDLE) |=> m_tvalid)
        else $error("finish step left no output word");

endmodule

`default_nettype wire

// ===== verif/tb_button_debounce_hold_actions.sv =====
// Self-checking testbench for button_debounce_hold_actions: streams millisecond ticks,
// predicts each result word from a cycle-free model of the debouncer and hold actions.
// Depends on rtl/bdha_pkg.sv and rtl/button_debounce_hold_actions.sv.
`timescale 1ns / 100ps

module tb_button_debounce_hold_actions;

    import bdha_pkg::*;

    localparam logic [2:0] REG_NONE       = 3'd7;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         RANDOM_PHASES  = 4;
    localparam int         PHASE_TICKS    = 50;

    typedef struct {
        logic        pressed;
        logic [23:0] hold_ms;
        logic        press_event;
        logic        long_press_event;
        logic        short_press_event;
        logic        action_valid;
        logic [7:0]  action_kind;
        logic [7:0]  action_cycle;
        logic        preview_valid;
        logic [7:0]  preview_cycle;
    } tick_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [2:0]        cfg_index = '0;
    logic [63:0]       cfg_data = '0;

    // Predictor copy of the registers.
    logic              pol_low = RST_ACTIVE_LOW;
    logic [7:0]        deb_limit = RST_DEBOUNCE;
    logic [15:0]       long_limit = RST_LONG_PRESS;
    logic [2:0]        n_actions = '0;
    logic [63:0]       thr_pack = '0;
    logic [3:0]        rel_mask = '0;
    logic [31:0]       kind_pack = '0;

    // Predictor copy of the button state.
    logic              last_lvl = 1'b0;
    logic              deb_state = 1'b0;
    logic [8:0]        stable_cnt = '0;
    logic [23:0]       hold_cnt = '0;
    logic              long_done = 1'b0;
    logic [7:0]        cyc_cnt = '0;
    logic [3:0]        fired = '0;

    logic              tick_level_q[$];
    tick_result_t      tick_expect_q[$];
    tick_result_t      exp_res;
    tick_result_t      got_res;

    int                err_count = 0;
    int                queued_count = 0;
    int                sent_count = 0;
    int                results_seen = 0;
    int                send_gap = 0;
    int                stall_left = 0;
    int                idle_cycles = 0;
    int                rx_pick;

    button_debounce_hold_actions dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5;
        clk = 1'b1;
        #5;
        clk = 1'b0;
    end

    function automatic tick_result_t predict_tick(input logic raw_in);
        tick_result_t res;
        logic         lvl;
        logic         released;
        logic         done;
        logic [23:0]  dur;
        logic [23:0]  quo;
        logic [15:0]  t0;
        int           live;
        int           i;
        res = '{default: '0};
        released = 1'b0;
        done = 1'b0;
        lvl = raw_in ^ pol_low;
        if (lvl != last_lvl)
            stable_cnt = '0;
        else if (stable_cnt != STABLE_MAX)
            stable_cnt = stable_cnt + 1'b1;
        last_lvl = lvl;

        // Hold as it would be after this tick if the press simply continues.
        dur = '0;
        if (deb_state)
            dur = (hold_cnt != HOLD_MAX) ? hold_cnt + 1'b1 : HOLD_MAX;
        if (stable_cnt > deb_limit && lvl != deb_state)
        begin
            deb_state = lvl;
            if (lvl)
            begin
                dur = '0;
                long_done = 1'b0;
                cyc_cnt = '0;
                fired = '0;
            end
            else
            begin
                released = 1'b1;
            end
        end
        hold_cnt = deb_state ? dur : '0;

        live = (n_actions > LIVE_LIMIT) ? LIVE_LIMIT : n_actions;
        t0 = thr_pack[15:0];
        if (live == 0)
        begin
            if (released && !long_done)
                res.press_event = 1'b1;
            if (deb_state && !long_done && hold_cnt >= long_limit)
            begin
                long_done = 1'b1;
                res.long_press_event = 1'b1;
            end
        end
        else if (deb_state)
        begin
            if (t0 != 0 && hold_cnt >= t0)
            begin
                quo = hold_cnt / {8'd0, t0};
                if (quo[7:0] != cyc_cnt)
                begin
                    cyc_cnt = quo[7:0];
                    res.preview_valid = 1'b1;
                    res.preview_cycle = quo[7:0];
                end
            end
            // Only the lowest eligible on-press action fires per tick.
            for (i = 0; i < live; i++)
            begin
                if (!done && hold_cnt >= thr_pack[16*i +: 16] && !rel_mask[i] && !fired[i])
                begin
                    fired[i] = 1'b1;
                    res.action_valid = 1'b1;
                    res.action_kind = kind_pack[8*i +: 8];
                    res.action_cycle = cyc_cnt;
                    done = 1'b1;
                end
            end
        end
        else if (released)
        begin
            for (i = live - 1; i >= 0; i--)
            begin
                if (!done && dur >= thr_pack[16*i +: 16] && rel_mask[i] && !fired[i])
                begin
                    res.action_valid = 1'b1;
                    res.action_kind = kind_pack[8*i +: 8];
                    res.action_cycle = cyc_cnt;
                    done = 1'b1;
                end
            end
            if (!done && dur < t0)
                res.short_press_event = 1'b1;
        end
        res.pressed = deb_state;
        res.hold_ms = hold_cnt;
        return res;
    endfunction

    function automatic int next_gap(input bit quiet);
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 60)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Fills the bits above a register field with garbage half of the time.
    function automatic logic [63:0] with_junk(input logic [63:0] val, input int width);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 0)
            return val;
        return (junk << width) | val;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ACTIVE_LOW:   pol_low = val[0];
            REG_DEBOUNCE_MS:  deb_limit = val[7:0];
            REG_LONG_PRESS:   long_limit = val[15:0];
            REG_ACTION_COUNT:
            begin
                n_actions = val[2:0];
                fired = '0;
            end
            REG_THRESHOLDS:   thr_pack = val;
            REG_ON_RELEASE:   rel_mask = val[3:0];
            REG_KINDS:        kind_pack = val[31:0];
            default:          ;
        endcase
    endtask

    // Queues ticks at a constant pressed or released level, in the current polarity.
    task automatic queue_level(input logic lvl, input int count);
        repeat (count)
        begin
            tick_level_q.push_back(lvl ^ pol_low);
            queued_count++;
        end
    endtask

    task automatic queue_bounce(input int count);
        repeat (count)
        begin
            tick_level_q.push_back(1'($urandom_range(0, 1)));
            queued_count++;
        end
    endtask

    // Bouncy press held hold_len ticks past adoption, then a bouncy release.
    task automatic queue_press(input int hold_len, input int rel_len);
        queue_bounce($urandom_range(0, 3));
        queue_level(1'b1, deb_limit + 2 + hold_len);
        queue_bounce($urandom_range(0, 3));
        queue_level(1'b0, deb_limit + 2 + rel_len);
    endtask

    // Waits until every queued tick has been accepted and its result checked.
    task automatic drain();
        do
            @(posedge clk);
        while (sent_count != queued_count || tick_expect_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_config();
        logic [15:0] thr[4];
        logic [63:0] pack;
        int          pick;
        int          k;
        write_reg(REG_ACTIVE_LOW, with_junk(64'($urandom_range(0, 1)), 1));
        pick = $urandom_range(0, 9);
        if (pick < 7)
            write_reg(REG_DEBOUNCE_MS, with_junk(64'($urandom_range(0, 3)), 8));
        else if (pick < 9)
            write_reg(REG_DEBOUNCE_MS, with_junk(64'($urandom_range(4, 12)), 8));
        else
            write_reg(REG_DEBOUNCE_MS, with_junk(64'($urandom_range(13, 30)), 8));
        pick = $urandom_range(0, 9);
        if (pick < 6)
            write_reg(REG_LONG_PRESS, with_junk(64'($urandom_range(0, 20)), 16));
        else if (pick < 8)
            write_reg(REG_LONG_PRESS, with_junk(64'd0, 16));
        else if (pick < 9)
            write_reg(REG_LONG_PRESS, with_junk(64'hFFFF, 16));
        else
            write_reg(REG_LONG_PRESS, with_junk(64'($urandom_range(0, 65535)), 16));
        pick = $urandom_range(0, 9);
        if (pick < 3)
            write_reg(REG_ACTION_COUNT, with_junk(64'd0, 3));
        else if (pick < 9)
            write_reg(REG_ACTION_COUNT, with_junk(64'($urandom_range(1, 4)), 3));
        else
            write_reg(REG_ACTION_COUNT, with_junk(64'($urandom_range(5, 7)), 3));
        pick = $urandom_range(0, 9);
        if (pick < 8)
        begin
            thr[0] = (pick < 2) ? 16'd0 : 16'($urandom_range(1, 6));
            for (k = 1; k < 4; k++)
                thr[k] = thr[k-1] + 16'($urandom_range(0, 6));
            pack = {thr[3], thr[2], thr[1], thr[0]};
        end
        else if (pick < 9)
        begin
            pack = {$urandom, $urandom};
        end
        else
        begin
            pack = '0;
        end
        write_reg(REG_THRESHOLDS, pack);
        write_reg(REG_ON_RELEASE, with_junk(64'($urandom_range(0, 15)), 4));
        write_reg(REG_KINDS, with_junk(64'($urandom), 32));
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_NONE, {$urandom, $urandom});
    endtask

    task automatic check_field(input string fname, input logic [23:0] want,
                               input logic [23:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
            err_count++;
        end
    endtask

    // Sender: one tick word per handshake, with random gaps between words.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                tick_expect_q.push_back(predict_tick(s_tdata[0]));
                sent_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (tick_level_q.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {{(IN_W-1){1'b0}}, tick_level_q.pop_front()};
                    send_gap <= next_gap(((sent_count / 64) % 3) == 0);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word and stalls at random, twice for a long stretch.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got_res.pressed = m_tdata[0];
                got_res.hold_ms = m_tdata[24:1];
                got_res.press_event = m_tdata[25];
                got_res.long_press_event = m_tdata[26];
                got_res.short_press_event = m_tdata[27];
                got_res.action_valid = m_tdata[28];
                got_res.action_kind = m_tdata[36:29];
                got_res.action_cycle = m_tdata[44:37];
                got_res.preview_valid = m_tdata[45];
                got_res.preview_cycle = m_tdata[53:46];
                if (tick_expect_q.size() == 0)
                begin
                    $display("%0t: result word %h arrived with nothing expected",
                             $time, m_tdata);
                    err_count++;
                end
                else
                begin
                    exp_res = tick_expect_q.pop_front();
                    check_field("pressed", exp_res.pressed, got_res.pressed);
                    check_field("hold_ms", exp_res.hold_ms, got_res.hold_ms);
                    check_field("press_event", exp_res.press_event, got_res.press_event);
                    check_field("long_press_event", exp_res.long_press_event,
                                got_res.long_press_event);
                    check_field("short_press_event", exp_res.short_press_event,
                                got_res.short_press_event);
                    check_field("action_valid", exp_res.action_valid, got_res.action_valid);
                    check_field("action_kind", exp_res.action_kind, got_res.action_kind);
                    check_field("action_cycle", exp_res.action_cycle, got_res.action_cycle);
                    check_field("preview_valid", exp_res.preview_valid,
                                got_res.preview_valid);
                    check_field("preview_cycle", exp_res.preview_cycle,
                                got_res.preview_cycle);
                end
            end
            rx_pick = $urandom_range(0, 99);
            if (m_tvalid && m_tready && (results_seen == 150 || results_seen == 400))
            begin
                m_tready <= 1'b0;
                stall_left <= 300;
            end
            else if (stall_left != 0)
            begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (((results_seen / 80) % 3) == 1 || rx_pick >= 14)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b0;
                stall_left <= (rx_pick < 12) ? $urandom_range(0, 3) : $urandom_range(10, 50);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int ph;
        int pick;
        int span;
        int live;
        int phase_start;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: a debounce of 50 ticks swallows a short press.
        queue_level(1'b1, 4);
        drain();

        // Simple mode with no debounce: a long press, then a plain press.
        write_reg(REG_ACTIVE_LOW, 64'd0);
        write_reg(REG_DEBOUNCE_MS, 64'd0);
        write_reg(REG_LONG_PRESS, 64'd2);
        write_reg(REG_ACTION_COUNT, 64'd0);
        write_reg(REG_NONE, '1);
        queue_level(1'b1, 5);
        queue_level(1'b0, 3);
        queue_level(1'b1, 3);
        queue_level(1'b0, 3);
        drain();

        // Too many actions, first threshold zero so no preview; two on-release actions.
        write_reg(REG_THRESHOLDS, {16'd5, 16'd3, 16'd2, 16'd0});
        write_reg(REG_ON_RELEASE, 64'hC);
        write_reg(REG_KINDS, 64'h4433_2211);
        write_reg(REG_ACTION_COUNT, 64'd7);
        queue_level(1'b1, 6);
        queue_level(1'b0, 3);
        drain();

        // A long hold with a first threshold of one: the preview cycle wraps past 255,
        // and the top action fires on release.
        write_reg(REG_ACTIVE_LOW, 64'd1);
        write_reg(REG_DEBOUNCE_MS, 64'd0);
        write_reg(REG_LONG_PRESS, 64'hFFFF);
        write_reg(REG_THRESHOLDS, {16'd250, 16'd200, 16'd100, 16'd1});
        write_reg(REG_ON_RELEASE, 64'h8);
        write_reg(REG_KINDS, 64'hFFFF_FFFF);
        write_reg(REG_ACTION_COUNT, 64'd4);
        queue_level(1'b1, 262);
        queue_level(1'b0, 3);
        drain();

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            random_config();
            live = (n_actions > LIVE_LIMIT) ? LIVE_LIMIT : n_actions;
            span = (live == 0) ? long_limit : thr_pack[16*(live-1) +: 16];
            span = (span > 36) ? 40 : span + 4;
            phase_start = queued_count;
            while (queued_count - phase_start < PHASE_TICKS)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    queue_bounce($urandom_range(1, 8));
                end
                else if (pick == 1)
                begin
                    // A press too short to be adopted.
                    queue_level(1'b1, $urandom_range(1, deb_limit + 1));
                    queue_level(1'b0, 2);
                end
                else
                begin
                    queue_press($urandom_range(0, span), $urandom_range(0, 4));
                end
            end
            drain();
        end

        repeat (30) @(posedge clk);
        if (tick_expect_q.size() != 0)
        begin
            $display("%0t: %0d expected result words never arrived",
                     $time, tick_expect_q.size());
            err_count++;
        end
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
